### hw/rtl/lsp_pkg.sv
// Shared types and constants of the looping sample player.
// Used by the top level and its testbench; depends on nothing.
package lsp_pkg;

	localparam int CMD_W           = 2;
	localparam int ADDR_W          = 21;
	localparam int VALUE_W         = 16;
	localparam int LEVEL_W         = 15;
	localparam int VOLUME_W        = 17;
	localparam int OUT_W           = 19;
	localparam int FRAME_COUNT_W   = 22;
	localparam int CHANNEL_COUNT_W = 2;
	localparam int STEP_W          = 20;
	localparam int CFG_W           = 22;
	localparam int CFG_INDEX_W     = 2;
	localparam int VOL5_W          = 19;

	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_RATIO    = 2'd2;

	localparam int OUT_LIMIT     = 163840;
	localparam int TRIG_HIGH_MV  = 2000;
	localparam int TRIG_LOW_MV   = 100;
	localparam int VOLUME_UNITY  = 65536;
	localparam int STEP_RESET    = 65536;

	typedef struct packed {
		logic start;
		logic done;
	} mod_ctl_t;

endpackage

### hw/rtl/looping_sample_player_top.sv
// Top level of the looping sample player: sample memory, cursor, sequencer.
// Depends on lsp_pkg and instantiates lsp_mod_unit.
//
// Usage: one input channel (in_valid/in_ready) carries commands. A write
// transaction stores sample_value at sample_address; a commit zeroes the
// play cursor. A tick transaction yields one output transaction (left_out,
// right_out) on out_valid/out_ready. The two cursor reductions run through
// one bit-serial remainder unit, and both channels share one multiplier and
// the single read port of the sample memory. With one frame or less a tick
// skips playback and outputs zero. in_ready is low while a tick is in work.
// A finished result waits in the output register; the next transaction is
// accepted meanwhile, but a following tick holds in its last state until
// that register is taken.
// Reset clears the cursor, the trigger and the configuration registers
// (frame_count 0, channel_count 1, step_ratio 1.0); sample memory is not
// cleared and must be written before it is played.
module looping_sample_player_top #(
	parameter int MEMORY_WORDS  = 2097152,
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [lsp_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [lsp_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [lsp_pkg::CMD_W-1:0]              command,
	input  logic [lsp_pkg::ADDR_W-1:0]             sample_address,
	input  logic signed [lsp_pkg::VALUE_W-1:0]     sample_value,
	input  logic signed [lsp_pkg::LEVEL_W-1:0]     reset_level,
	input  logic [lsp_pkg::VOLUME_W-1:0]           volume,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [lsp_pkg::OUT_W-1:0]       left_out,
	output logic signed [lsp_pkg::OUT_W-1:0]       right_out
);

	localparam int AW         = $clog2(MEMORY_WORDS);
	localparam int W          = AW + 1;
	localparam int SB         = SAMPLE_BITS;
	localparam int F          = FRACTION_BITS;
	localparam int SAMPLE_UP  = (SB >= 16) ? SB - 16 : 0;
	localparam int SAMPLE_DN  = (SB < 16) ? 16 - SB : 0;
	localparam int STEP_UP    = (F >= 16) ? F - 16 : 0;
	localparam int STEP_DN    = (F < 16) ? 16 - F : 0;
	localparam int DROP       = (F > 16) ? F - 16 : 0;
	localparam int IB         = F - DROP;
	localparam int QW         = SB + IB;
	localparam int MB         = ((F > lsp_pkg::VOL5_W) ? F : lsp_pkg::VOL5_W) + 1;
	localparam int PW         = QW + MB;
	localparam int SH         = IB + SB;
	localparam int STW        = lsp_pkg::STEP_W + STEP_UP;
	localparam int PSW        = W + F;
	localparam int CMPW       = (lsp_pkg::FRAME_COUNT_W > W) ? lsp_pkg::FRAME_COUNT_W : W;
	localparam int AXW        = ((lsp_pkg::ADDR_W > AW) ? lsp_pkg::ADDR_W : AW) + 1;
	localparam int WIDEW      = SB + 17;
	localparam int MAXF_MONO  = MEMORY_WORDS;
	localparam int MAXF_STEREO = MEMORY_WORDS / 2;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_MOD1  = 11'b000_0000_0010,
		ST_RD_A  = 11'b000_0000_0100,
		ST_RD_B  = 11'b000_0000_1000,
		ST_MUL_D = 11'b000_0001_0000,
		ST_SUM   = 11'b000_0010_0000,
		ST_MUL_V = 11'b000_0100_0000,
		ST_RND   = 11'b000_1000_0000,
		ST_ADV   = 11'b001_0000_0000,
		ST_MOD2  = 11'b010_0000_0000,
		ST_OUT   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic [lsp_pkg::FRAME_COUNT_W-1:0]   frame_count_q;
	logic [lsp_pkg::CHANNEL_COUNT_W-1:0] channel_count_q;
	logic [lsp_pkg::STEP_W-1:0]          step_ratio_q;
	logic [AW-1:0]                       cursor_whole_q;
	logic [F-1:0]                        cursor_frac_q;
	logic                                trig_q;
	logic                                out_valid_q;
	logic                                chan_q;

	logic signed [SB-1:0]                mem [MEMORY_WORDS];
	logic signed [SB-1:0]                rd_q;
	logic signed [SB-1:0]                a_q;
	logic [AW-1:0]                       first_q;
	logic [AW-1:0]                       second_q;
	logic [lsp_pkg::VOL5_W-1:0]          vol5_q;
	logic signed [PW-1:0]                prod_q;
	logic signed [QW-1:0]                q_q;
	logic signed [lsp_pkg::OUT_W-1:0]    res_left_q;
	logic signed [lsp_pkg::OUT_W-1:0]    res_right_q;
	logic signed [lsp_pkg::OUT_W-1:0]    out_left_q;
	logic signed [lsp_pkg::OUT_W-1:0]    out_right_q;

	logic                                stereo;
	logic [CMPW-1:0]                     maxf;
	logic [CMPW-1:0]                     frames_wide;
	logic [W-1:0]                        frames;
	logic                                short_loop;
	logic                                accept;
	logic                                is_tick;
	logic                                trig_fire;
	logic                                trig_next;
	logic                                wr_hit;
	logic [AXW-1:0]                      addr_ext;
	logic signed [WIDEW-1:0]             wr_wide;
	logic [lsp_pkg::VOLUME_W-1:0]        vol_clamp;
	logic [AW-1:0]                       rd_addr;
	logic [AW-1:0]                       frame_sel;
	logic signed [SB:0]                  diff;
	logic signed [QW-1:0]                op_a;
	logic signed [MB-1:0]                op_b;
	logic signed [PW-1:0]                mult;
	logic signed [PW-1:0]                full;
	logic signed [PW-1:0]                rnd_full;
	logic signed [PW-1:0]                rnd;
	logic signed [lsp_pkg::OUT_W-1:0]    sat;
	logic [STW-1:0]                      step_w;
	logic [PSW-1:0]                      pos;
	logic [W:0]                          next_first;
	logic                                out_free;
	lsp_pkg::mod_ctl_t                   mod_ctl;
	logic [W-1:0]                        mod_dividend;
	logic [W-1:0]                        mod_rem;

	assign stereo      = channel_count_q[1];
	assign maxf        = stereo ? CMPW'(MAXF_STEREO) : CMPW'(MAXF_MONO);
	assign frames_wide = (CMPW'(frame_count_q) < maxf) ? CMPW'(frame_count_q) : maxf;
	assign frames      = frames_wide[W-1:0];
	assign short_loop  = frames <= W'(1);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_tick   = (command == lsp_pkg::CMD_TICK);

	assign trig_fire = !trig_q && (reset_level >= lsp_pkg::LEVEL_W'(lsp_pkg::TRIG_HIGH_MV));
	assign trig_next = trig_q ? !(reset_level <= lsp_pkg::LEVEL_W'(lsp_pkg::TRIG_LOW_MV))
	                          : trig_fire;

	assign addr_ext  = AXW'(sample_address);
	assign wr_hit    = accept && (command == lsp_pkg::CMD_WRITE)
	                   && (addr_ext < AXW'(MEMORY_WORDS));
	assign wr_wide   = (WIDEW'(sample_value) <<< SAMPLE_UP) >>> SAMPLE_DN;

	assign vol_clamp = (volume > lsp_pkg::VOLUME_W'(lsp_pkg::VOLUME_UNITY))
	                   ? lsp_pkg::VOLUME_W'(lsp_pkg::VOLUME_UNITY) : volume;

	assign frame_sel = (state_q == ST_RD_B) ? second_q : first_q;
	assign rd_addr   = stereo ? {frame_sel[AW-2:0], chan_q} : frame_sel;

	assign diff  = (SB + 1)'(rd_q) - (SB + 1)'(a_q);
	assign op_a  = (state_q == ST_MUL_V) ? q_q : QW'(diff);
	assign op_b  = (state_q == ST_MUL_V) ? signed'(MB'(vol5_q)) : signed'(MB'(cursor_frac_q));
	assign mult  = PW'(op_a) * PW'(op_b);

	assign full     = (PW'(a_q) <<< F) + prod_q;
	assign rnd_full = prod_q + (PW'(1) <<< (SH - 1));
	assign rnd      = rnd_full >>> SH;
	assign sat      = (rnd > PW'(lsp_pkg::OUT_LIMIT)) ? lsp_pkg::OUT_W'(lsp_pkg::OUT_LIMIT)
	                : (rnd < -PW'(lsp_pkg::OUT_LIMIT)) ? -lsp_pkg::OUT_W'(lsp_pkg::OUT_LIMIT)
	                : rnd[lsp_pkg::OUT_W-1:0];

	assign step_w     = (STW'(step_ratio_q) << STEP_UP) >> STEP_DN;
	assign pos        = {1'b0, first_q, cursor_frac_q} + PSW'(step_w);
	assign next_first = (W + 1)'(mod_rem) + (W + 1)'(1);
	assign out_free   = !out_valid_q || out_ready;

	assign mod_ctl.start = (accept && is_tick && !short_loop) || (state_q == ST_ADV);
	assign mod_dividend  = (state_q == ST_ADV) ? pos[PSW-1:F]
	                     : (trig_fire ? '0 : W'(cursor_whole_q));

	lsp_mod_unit #(
		.W(W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_ctl.start),
		.dividend  (mod_dividend),
		.divisor   (frames),
		.done      (mod_ctl.done),
		.remainder (mod_rem)
	);

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[addr_ext[AW-1:0]] <= wr_wide[SB-1:0];
		end
		if (state_q == ST_RD_A || state_q == ST_RD_B) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			frame_count_q   <= '0;
			channel_count_q <= lsp_pkg::CHANNEL_COUNT_W'(1);
			step_ratio_q    <= lsp_pkg::STEP_W'(lsp_pkg::STEP_RESET);
			cursor_whole_q  <= '0;
			cursor_frac_q   <= '0;
			trig_q          <= 1'b0;
			out_valid_q     <= 1'b0;
			chan_q          <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					lsp_pkg::REG_FRAME_COUNT: begin
						frame_count_q <= cfg_data[lsp_pkg::FRAME_COUNT_W-1:0];
					end
					lsp_pkg::REG_CHANNEL_COUNT: begin
						channel_count_q <= cfg_data[lsp_pkg::CHANNEL_COUNT_W-1:0];
					end
					lsp_pkg::REG_STEP_RATIO: begin
						step_ratio_q <= cfg_data[lsp_pkg::STEP_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && command == lsp_pkg::CMD_COMMIT) begin
						cursor_whole_q <= '0;
						cursor_frac_q  <= '0;
					end else if (accept && is_tick) begin
						trig_q <= trig_next;
						if (trig_fire) begin
							cursor_whole_q <= '0;
							cursor_frac_q  <= '0;
						end
						state_q <= short_loop ? ST_OUT : ST_MOD1;
					end
				end
				ST_MOD1: begin
					chan_q <= 1'b0;
					if (mod_ctl.done) begin
						state_q <= ST_RD_A;
					end
				end
				ST_RD_A: begin
					state_q <= ST_RD_B;
				end
				ST_RD_B: begin
					state_q <= ST_MUL_D;
				end
				ST_MUL_D: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_MUL_V;
				end
				ST_MUL_V: begin
					state_q <= ST_RND;
				end
				ST_RND: begin
					if (stereo && !chan_q) begin
						chan_q  <= 1'b1;
						state_q <= ST_RD_A;
					end else begin
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					cursor_frac_q <= pos[F-1:0];
					state_q       <= ST_MOD2;
				end
				ST_MOD2: begin
					if (mod_ctl.done) begin
						cursor_whole_q <= mod_rem[AW-1:0];
						state_q        <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				vol5_q      <= lsp_pkg::VOL5_W'(vol_clamp) + {vol_clamp, 2'b00};
				res_left_q  <= '0;
				res_right_q <= '0;
			end
			ST_MOD1: begin
				first_q  <= mod_rem[AW-1:0];
				second_q <= (next_first == (W + 1)'(frames)) ? '0 : next_first[AW-1:0];
			end
			ST_MUL_D: begin
				a_q    <= a_q;
				prod_q <= mult;
			end
			ST_RD_B: begin
				a_q <= rd_q;
			end
			ST_SUM: begin
				q_q <= QW'(full >>> DROP);
			end
			ST_MUL_V: begin
				prod_q <= mult;
			end
			ST_RND: begin
				if (chan_q) begin
					res_right_q <= sat;
				end else begin
					res_left_q <= sat;
					if (!stereo) begin
						res_right_q <= sat;
					end
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_left_q  <= res_left_q;
					out_right_q <= res_right_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign left_out  = out_left_q;
	assign right_out = out_right_q;

	a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mod_ctl.done |-> (state_q == ST_MOD1 || state_q == ST_MOD2))
		else $error("remainder unit finished outside a wait state");

	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished tick did not reach the output register");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_tick) |=> !in_ready)
		else $error("tick transaction did not hold off the input");

endmodule

### hw/rtl/lsp_mod_unit.sv
// Iterative remainder unit, one restoring step per cycle.
// Depends on no other file.
module lsp_mod_unit #(
	parameter int W = 22
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [W-1:0]     dividend,
	input  logic [W-1:0]     divisor,
	output logic             done,
	output logic [W-1:0]     remainder
);

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {rem_q, dvd_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= diff[W] ? trial[W-1:0] : diff[W-1:0];
			dvd_q <= {dvd_q[W-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

### verif/looping_sample_player_top_tb.sv
// Self-checking testbench for the looping sample player top level.
// Depends on lsp_pkg and looping_sample_player_top; it predicts every output
// transaction with its own model of memory, cursor, trigger and settings.
module looping_sample_player_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lsp_pkg::*;

	localparam int MEM_WORDS = 2097152;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 80;
	localparam int MAX_SHOWN = 10;
	localparam int RANDOM_ITEMS = 950;

	typedef struct packed {
		logic signed [OUT_W-1:0] left;
		logic signed [OUT_W-1:0] right;
	} frame_out_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [CMD_W-1:0] command;
	logic [ADDR_W-1:0] sample_address;
	logic signed [VALUE_W-1:0] sample_value;
	logic signed [LEVEL_W-1:0] reset_level;
	logic [VOLUME_W-1:0] volume;
	logic out_valid;
	logic out_ready;
	logic signed [OUT_W-1:0] left_out;
	logic signed [OUT_W-1:0] right_out;

	logic signed [VALUE_W-1:0] sample_mem [int unsigned];
	int unsigned cur_whole;
	int unsigned cur_frac;
	bit trig_high;
	int unsigned loop_frames_reg;
	int unsigned chan_reg;
	int unsigned step_reg;
	frame_out_t pending_frames [$];

	int unsigned n_ticks;
	int unsigned n_writes;
	int unsigned n_commits;
	int unsigned n_unused;
	int unsigned n_checked;
	int unsigned n_mismatch;
	int unsigned n_settings;
	int unsigned n_random;
	int burst_left;

	looping_sample_player_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.sample_address(sample_address),
		.sample_value(sample_value),
		.reset_level(reset_level),
		.volume(volume),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_out(left_out),
		.right_out(right_out)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned eff_channels();
		return (chan_reg == 0) ? 1 : ((chan_reg > 2) ? 2 : chan_reg);
	endfunction

	function automatic int unsigned eff_frames();
		int unsigned maxf;
		maxf = MEM_WORDS / eff_channels();
		return (loop_frames_reg < maxf) ? loop_frames_reg : maxf;
	endfunction

	function automatic longint blend(int unsigned i0, int unsigned i1, int unsigned frac);
		longint a;
		longint b;
		a = sample_mem[i0];
		b = sample_mem[i1];
		return a * 65536 + (b - a) * longint'(frac);
	endfunction

	function automatic logic signed [OUT_W-1:0] to_volts(longint q, longint vol);
		longint r;
		r = (q * 5 * vol + 64'sd2147483648) >>> 32;
		if (r > OUT_LIMIT)
			r = OUT_LIMIT;
		if (r < -OUT_LIMIT)
			r = -OUT_LIMIT;
		return r[OUT_W-1:0];
	endfunction

	// Runs the trigger; with two or more frames, interpolates both channels and advances the cursor.
	function automatic frame_out_t next_output_frame(logic signed [LEVEL_W-1:0] level,
			logic [VOLUME_W-1:0] vol_in);
		frame_out_t res;
		longint vol;
		longint pos;
		int unsigned ch;
		int unsigned frames;
		int unsigned first;
		int unsigned second;
		int unsigned rc;
		if (trig_high) begin
			if (level <= TRIG_LOW_MV)
				trig_high = 1'b0;
		end else if (level >= TRIG_HIGH_MV) begin
			trig_high = 1'b1;
			cur_whole = 0;
			cur_frac = 0;
		end
		vol = (vol_in > VOLUME_UNITY) ? VOLUME_UNITY : vol_in;
		ch = eff_channels();
		frames = eff_frames();
		res = '0;
		if (frames <= 1)
			return res;
		first = cur_whole % frames;
		second = (first + 1) % frames;
		rc = (ch > 1) ? 1 : 0;
		res.left = to_volts(blend(first * ch, second * ch, cur_frac), vol);
		res.right = to_volts(blend(first * ch + rc, second * ch + rc, cur_frac), vol);
		pos = (longint'(first) << 16) + longint'(cur_frac) + longint'(step_reg);
		cur_frac = pos[15:0];
		cur_whole = (pos >> 16) % frames;
		return res;
	endfunction

	function automatic logic signed [LEVEL_W-1:0] random_level();
		case ($urandom_range(0, 2))
			0: return $urandom_range(0, 24000) - 12000;
			1: return $urandom_range(1950, 2050);
			default: return $urandom_range(0, 200) - 50;
		endcase
	endfunction

	function automatic logic [VOLUME_W-1:0] random_volume();
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(0, VOLUME_UNITY);
		return $urandom_range(0, 131071);
	endfunction

	task automatic send_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
			logic signed [VALUE_W-1:0] val, logic signed [LEVEL_W-1:0] level,
			logic [VOLUME_W-1:0] vol);
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(20, 80)) @(posedge clk);
			else
				repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= cmd;
		sample_address <= addr;
		sample_value <= val;
		reset_level <= level;
		volume <= vol;
		do
			@(posedge clk);
		while (!in_ready);
		case (cmd)
			CMD_TICK: begin
				pending_frames.push_back(next_output_frame(level, vol));
				n_ticks++;
			end
			CMD_WRITE: begin
				sample_mem[addr] = val;
				n_writes++;
			end
			CMD_COMMIT: begin
				cur_whole = 0;
				cur_frac = 0;
				n_commits++;
			end
			default: n_unused++;
		endcase
	endtask

	task automatic write_word(int unsigned addr, int val);
		send_item(CMD_WRITE, addr, val, $urandom, $urandom);
	endtask

	// Fills the two frames the next tick will read if they were never written.
	task automatic ensure_loaded(logic signed [LEVEL_W-1:0] level);
		int unsigned ch;
		int unsigned frames;
		int unsigned whole;
		int unsigned first;
		int unsigned second;
		int unsigned rc;
		int unsigned addrs [4];
		ch = eff_channels();
		frames = eff_frames();
		if (frames <= 1)
			return;
		whole = (!trig_high && level >= TRIG_HIGH_MV) ? 0 : cur_whole;
		first = whole % frames;
		second = (first + 1) % frames;
		rc = (ch > 1) ? 1 : 0;
		addrs = '{first * ch, first * ch + rc, second * ch, second * ch + rc};
		foreach (addrs[k])
			if (!sample_mem.exists(addrs[k]))
				write_word(addrs[k], $urandom);
	endtask

	task automatic tick(logic signed [LEVEL_W-1:0] level, logic [VOLUME_W-1:0] vol);
		ensure_loaded(level);
		send_item(CMD_TICK, $urandom, $urandom, level, vol);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_settings(int unsigned frames, int unsigned ch, int unsigned step);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_FRAME_COUNT;
		cfg_data <= frames[CFG_W-1:0];
		@(posedge clk);
		cfg_index <= REG_CHANNEL_COUNT;
		cfg_data <= ch[CFG_W-1:0];
		@(posedge clk);
		cfg_index <= REG_STEP_RATIO;
		cfg_data <= step[CFG_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		loop_frames_reg = frames & 32'h3F_FFFF;
		chan_reg = ch & 32'h3;
		step_reg = step & 32'hF_FFFF;
		n_settings++;
	endtask

	task automatic test_reset_state();
		tick(0, VOLUME_UNITY);
		tick(-12000, 131071);
	endtask

	task automatic test_mono_playback();
		load_settings(4, 1, 24576);
		write_word(0, -32768);
		write_word(1, 32767);
		write_word(2, 0);
		write_word(3, -1);
		tick(0, VOLUME_UNITY);
		tick(-12000, 0);
		tick(1999, 131071);
		tick(2000, 65537);
		tick(101, VOLUME_UNITY);
		tick(100, VOLUME_UNITY);
		tick(12000, 1);
		send_item(CMD_COMMIT, $urandom, $urandom, $urandom, $urandom);
		send_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
		write_word(MEM_WORDS - 1, 32767);
		tick(0, VOLUME_UNITY);
	endtask

	task automatic test_stereo_playback();
		load_settings(2, 2, 20'hF_FFFF);
		write_word(0, 32767);
		write_word(1, -32768);
		write_word(2, -32768);
		write_word(3, 32767);
		tick(0, VOLUME_UNITY);
		tick(0, 40000);
		load_settings(3, 3, 1);
		tick(0, VOLUME_UNITY);
		load_settings(5, 0, 65535);
		tick(0, VOLUME_UNITY);
	endtask

	task automatic test_short_loop();
		load_settings(1, 1, STEP_RESET);
		tick(0, VOLUME_UNITY);
		load_settings(0, 2, 0);
		tick(0, VOLUME_UNITY);
	endtask

	task automatic test_cursor_wrap();
		load_settings(16, 1, 20'hF_FFFF);
		tick(0, VOLUME_UNITY);
		tick(0, VOLUME_UNITY);
		load_settings(3, 1, STEP_RESET);
		tick(0, VOLUME_UNITY);
		tick(0, VOLUME_UNITY);
	endtask

	task automatic test_saturated_loop();
		load_settings(22'h3F_FFFF, 1, 20'hF_FFFF);
		tick(0, VOLUME_UNITY);
		tick(0, VOLUME_UNITY);
		load_settings(MEM_WORDS, 2, 20'h8_0000);
		tick(0, VOLUME_UNITY);
		tick(0, VOLUME_UNITY);
	endtask

	task automatic test_random_traffic();
		int unsigned frames;
		int unsigned ch;
		int unsigned step;
		int unsigned span;
		int unsigned pick;
		while (n_random < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 8)
				frames = $urandom_range(2, 48);
			else if (pick == 8)
				frames = $urandom_range(0, 1);
			else
				frames = $urandom_range(1000, 22'h3F_FFFF);
			ch = $urandom_range(0, 3);
			case ($urandom_range(0, 2))
				0: step = $urandom_range(0, 20'hF_FFFF);
				1: step = $urandom_range(20'h0_8000, 20'h2_0000);
				default: begin
					pick = $urandom_range(0, 2);
					step = (pick == 0) ? 0 : ((pick == 1) ? STEP_RESET : 20'hF_FFFF);
				end
			endcase
			load_settings(frames, ch, step);
			span = eff_frames() * eff_channels();
			if (span > 96)
				span = 96;
			if (span == 0)
				span = 1;
			repeat ($urandom_range(30, 120)) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					tick(random_level(), random_volume());
				else if (pick < 78)
					write_word($urandom_range(0, span - 1), $urandom);
				else if (pick < 88)
					write_word($urandom_range(0, MEM_WORDS - 1), $urandom);
				else if (pick < 95)
					send_item(CMD_COMMIT, $urandom, $urandom, $urandom, $urandom);
				else
					send_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
				if (pick < 95)
					n_random++;
			end
		end
	endtask

	initial begin
		int unsigned mode;
		int unsigned phase;
		logic [7:0] pattern;
		out_ready <= 1'b0;
		phase = 0;
		forever begin
			mode = $urandom_range(0, 3);
			pattern = $urandom_range(1, 255);
			repeat ($urandom_range(20, 200)) begin
				@(posedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= ($urandom_range(0, 7) == 0);
					default: begin
						out_ready <= pattern[phase % 8];
						phase++;
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_outputs
		frame_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_frames.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= MAX_SHOWN)
					$display("Unexpected output transaction: left %0d right %0d",
						left_out, right_out);
			end else begin
				want = pending_frames.pop_front();
				n_checked++;
				if (left_out !== want.left || right_out !== want.right) begin
					n_mismatch++;
					if (n_mismatch <= MAX_SHOWN)
						$display("Mismatch on output %0d: left exp %0d got %0d, right exp %0d got %0d",
							n_checked, want.left, left_out, want.right, right_out);
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("Timeout with %0d output transactions still pending", pending_frames.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_FRAME_COUNT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		command <= CMD_TICK;
		sample_address <= '0;
		sample_value <= '0;
		reset_level <= '0;
		volume <= '0;
		cur_whole = 0;
		cur_frac = 0;
		trig_high = 1'b0;
		loop_frames_reg = 0;
		chan_reg = 1;
		step_reg = STEP_RESET;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_mono_playback();
		test_stereo_playback();
		test_short_loop();
		test_cursor_wrap();
		test_saturated_loop();
		test_random_traffic();
		wait_idle();
		$display("Ran %0d ticks, %0d sample writes, %0d commits and %0d unused commands",
			n_ticks, n_writes, n_commits, n_unused);
		$display("over %0d register settings; %0d output transactions checked, %0d mismatches.",
			n_settings, n_checked, n_mismatch);
		if (n_mismatch == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
